### rtl/itpd_pkg.sv
// ----------------------------------------------------------------------------
// itpd_pkg: shared constants and types for the tilt-controlled paddle
// Field widths, fixed-point constants, the arctangent table and the
// sequencer and register codes used across the block.
// ----------------------------------------------------------------------------
package itpd_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int LOWPASS_SHIFT = 4;
  localparam int ARCTAN_STEPS  = 16;
  localparam int TABLE_LEN     = 24;

  localparam int ACCEL_W  = 22;
  localparam int GYRO_W   = 28;
  localparam int GAIN_W   = 17;
  localparam int LIMIT_W  = 17;
  localparam int PMAX_W   = 25;
  localparam int CENTER_W = 24;
  localparam int TILT_W   = 25;
  localparam int ANGLE_W  = 24;
  localparam int VEL_W    = 18;
  localparam int POS_W    = 25;
  localparam int BLEND_W  = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 25;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 96;

  localparam int CORDIC_W    = 25;
  localparam int Z_W         = 25;
  localparam int STEP_W      = $clog2(ARCTAN_STEPS);
  localparam int TABLE_IDX_W = $clog2(TABLE_LEN);
  localparam int ATAN_TAB_W  = 38;

  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 17;
  localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W - FRACTION_BITS;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam logic [MUL_B_W-1:0] C001 = MUL_B_W'((64'd1 << FRACTION_BITS) / 1000);
  localparam logic [MUL_B_W-1:0] C999 = MUL_B_W'((64'd999 << FRACTION_BITS) / 1000);

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'((64'd5 << FRACTION_BITS) / 1000);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'((64'd9 << FRACTION_BITS) / 10);
  localparam logic [PMAX_W-1:0]   PMAX_RESET   = PMAX_W'(64'd420 << FRACTION_BITS);
  localparam logic [CENTER_W-1:0] CENTER_RESET = CENTER_W'(64'd90 << FRACTION_BITS);
  localparam logic [POS_W-1:0]    TOP_RESET    = POS_W'(64'd240 << FRACTION_BITS);

  localparam logic signed [Z_W-1:0] Z_DEG_90    = Z_W'(64'd90 << FRACTION_BITS);
  localparam logic signed [Z_W:0]   TILT_OFFSET = (Z_W+1)'(64'd180 << FRACTION_BITS);
  localparam logic signed [Z_W:0]   TILT_MAX    = (Z_W+1)'(64'd360 << FRACTION_BITS);
  localparam logic [ANGLE_W-1:0]    ANGLE_MAX   = ANGLE_W'(64'd180 << FRACTION_BITS);

  // atan(2^-i) in degrees, scaled by 2^32
  localparam logic [ATAN_TAB_W-1:0] ATAN_DEG_2P32 [TABLE_LEN] = '{
    38'd193273528320, 38'd114096026022, 38'd60285206653, 38'd30601712202,
    38'd15360239180,  38'd7687607525,   38'd3844741810,  38'd1922488225,
    38'd961258780,    38'd480631223,    38'd240315841,   38'd120157949,
    38'd60078978,     38'd30039489,     38'd15019745,    38'd7509872,
    38'd3754936,      38'd1877468,      38'd938734,      38'd469367,
    38'd234684,       38'd117342,       38'd58671,       38'd29335
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VELOCITY_GAIN  = 2'd0,
    REG_VELOCITY_LIMIT = 2'd1,
    REG_POSITION_MAX   = 2'd2,
    REG_CENTER_ANGLE   = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILTER,
    ST_CORDIC,
    ST_DECAY,
    ST_TILT_MUL,
    ST_SMOOTH,
    ST_GAIN,
    ST_VEL,
    ST_POSITION
  } seq_state_t;

  // Table entry rounded half up to the working fraction width.
  function automatic logic [Z_W-1:0] atan_q(input logic [TABLE_IDX_W-1:0] idx);
    logic [ATAN_TAB_W-1:0] r;
    r = '0;
    if (int'(idx) < TABLE_LEN) begin
      r = ATAN_DEG_2P32[idx] + (ATAN_TAB_W'(1) << (32 - FRACTION_BITS - 1));
    end
    return Z_W'(r >> (32 - FRACTION_BITS));
  endfunction

endpackage

### rtl/imu_tilt_complementary_paddle.sv
// ----------------------------------------------------------------------------
// imu_tilt_complementary_paddle: IMU tilt estimate driving a paddle position
// One input beat is processed at a time: in_tready is high only in idle,
// after the previous result is loaded. Four 17-step multiplies share the
// one bit-serial multiplier; the 16-step CORDIC runs beside the first of them.
// Reset (synchronous, rst_n low) clears the filters and reloads the registers.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_paddle import itpd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // accel_y [21:0], accel_z [43:22], gyro_x [71:44]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accel_tilt [24:0], filtered_angle [48:25], paddle_velocity [66:49],
  // paddle_position [91:67], zero fill [95:92]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  seq_state_t state_r, state_nxt;

  logic signed [ACCEL_W-1:0] ay_r, az_r, say_r, saz_r;
  logic signed [GYRO_W-1:0]  gx_r;
  logic signed [BLEND_W-1:0] blend_r;
  logic signed [MUL_P_W-1:0] decay_r;
  logic        [ANGLE_W-1:0] smooth_r;
  logic        [TILT_W-1:0]  tilt_r;
  logic signed [VEL_W-1:0]   vel_r;
  logic        [POS_W-1:0]   top_r;
  logic        [GAIN_W-1:0]  gain_r;
  logic        [LIMIT_W-1:0] limit_r;
  logic        [PMAX_W-1:0]  pmax_r;
  logic        [CENTER_W-1:0] center_r;
  logic                      out_valid_r;
  logic [OUT_TDATA_W-1:0]    out_data_r;

  logic accept, ld_filter, ld_tilt, ld_decay, ld_blend, ld_smooth, ld_vel, ld_out;

  logic                      cordic_start, cordic_busy;
  logic signed [Z_W-1:0]     cordic_z;
  logic                      mul_start, mul_busy;
  logic signed [MUL_A_W-1:0] mul_mcand;
  logic        [MUL_B_W-1:0] mul_mplier;
  logic signed [MUL_P_W-1:0] mul_product;

  logic signed [ACCEL_W:0]   diff_y, diff_z;
  logic signed [ACCEL_W-1:0] say_new, saz_new;
  logic signed [Z_W:0]       tilt_sum;
  logic        [TILT_W-1:0]  tilt_new;
  logic signed [MUL_A_W-1:0] blend_gyro;
  logic signed [MUL_P_W:0]   blend_sum;
  logic [MUL_P_W-BLEND_W+1:0] blend_upper;
  logic signed [BLEND_W-1:0] blend_new;
  logic signed [BLEND_W+1:0] sm_base, sm_diff, sm_sum;
  logic        [ANGLE_W-1:0] smooth_new;
  logic signed [MUL_A_W-1:0] gain_mcand;
  logic signed [MUL_P_W-1:0] vel_raw, vel_lim;
  logic signed [VEL_W-1:0]   vel_new;
  logic signed [POS_W+1:0]   pos_sum;
  logic        [POS_W-1:0]   top_new;

  itpd_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (say_new),
    .y_in  (-(ACCEL_W+1)'(saz_new)),
    .busy  (cordic_busy),
    .angle (cordic_z)
  );

  itpd_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .busy    (mul_busy),
    .product (mul_product)
  );

  always_comb begin
    diff_y  = (ACCEL_W+1)'(ay_r) - (ACCEL_W+1)'(say_r);
    diff_z  = (ACCEL_W+1)'(az_r) - (ACCEL_W+1)'(saz_r);
    say_new = ACCEL_W'((ACCEL_W+1)'(say_r) + (diff_y >>> LOWPASS_SHIFT));
    saz_new = ACCEL_W'((ACCEL_W+1)'(saz_r) + (diff_z >>> LOWPASS_SHIFT));

    tilt_sum = (Z_W+1)'(cordic_z) + TILT_OFFSET;
    if (tilt_sum < 0) begin
      tilt_new = '0;
    end else if (tilt_sum > TILT_MAX) begin
      tilt_new = TILT_W'(TILT_MAX);
    end else begin
      tilt_new = TILT_W'(tilt_sum);
    end

    blend_gyro  = MUL_A_W'(blend_r) + MUL_A_W'(mul_product);
    blend_sum   = (MUL_P_W+1)'(decay_r) + (MUL_P_W+1)'(mul_product);
    blend_upper = blend_sum[MUL_P_W:BLEND_W-1];
    if (blend_upper == '0 || blend_upper == '1) begin
      blend_new = blend_sum[BLEND_W-1:0];
    end else if (blend_sum[MUL_P_W]) begin
      blend_new = {1'b1, {(BLEND_W-1){1'b0}}};
    end else begin
      blend_new = {1'b0, {(BLEND_W-1){1'b1}}};
    end

    sm_base = (BLEND_W+2)'($signed({1'b0, smooth_r}));
    sm_diff = (BLEND_W+2)'(blend_r) - sm_base;
    sm_sum  = sm_base + (sm_diff >>> LOWPASS_SHIFT);
    if (sm_sum < 0) begin
      smooth_new = '0;
    end else if (sm_sum > (BLEND_W+2)'($signed({1'b0, ANGLE_MAX}))) begin
      smooth_new = ANGLE_MAX;
    end else begin
      smooth_new = sm_sum[ANGLE_W-1:0];
    end

    gain_mcand = MUL_A_W'($signed({1'b0, smooth_r}) - $signed({1'b0, center_r}));
    vel_raw    = -mul_product;
    vel_lim    = MUL_P_W'($signed({1'b0, limit_r}));
    if (vel_raw > vel_lim) begin
      vel_new = VEL_W'(vel_lim);
    end else if (vel_raw < -vel_lim) begin
      vel_new = VEL_W'(-vel_lim);
    end else begin
      vel_new = VEL_W'(vel_raw);
    end

    pos_sum = (POS_W+2)'($signed({1'b0, top_r})) + (POS_W+2)'(vel_r);
    if (pos_sum <= 0) begin
      top_new = '0;
    end else if (pos_sum >= (POS_W+2)'($signed({1'b0, pmax_r}))) begin
      top_new = pmax_r;
    end else begin
      top_new = pos_sum[POS_W-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    accept       = 1'b0;
    ld_filter    = 1'b0;
    ld_tilt      = 1'b0;
    ld_decay     = 1'b0;
    ld_blend     = 1'b0;
    ld_smooth    = 1'b0;
    ld_vel       = 1'b0;
    ld_out       = 1'b0;
    cordic_start = 1'b0;
    mul_start    = 1'b0;
    mul_mcand    = '0;
    mul_mplier   = '0;
    in_tready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          accept    = 1'b1;
          state_nxt = ST_FILTER;
        end
      end
      ST_FILTER: begin
        ld_filter    = 1'b1;
        cordic_start = 1'b1;
        mul_start    = 1'b1;
        mul_mcand    = MUL_A_W'(gx_r);
        mul_mplier   = C001;
        state_nxt    = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (!cordic_busy && !mul_busy) begin
          ld_tilt    = 1'b1;
          mul_start  = 1'b1;
          mul_mcand  = blend_gyro;
          mul_mplier = C999;
          state_nxt  = ST_DECAY;
        end
      end
      ST_DECAY: begin
        if (!mul_busy) begin
          ld_decay   = 1'b1;
          mul_start  = 1'b1;
          mul_mcand  = MUL_A_W'($signed({1'b0, tilt_r}));
          mul_mplier = C001;
          state_nxt  = ST_TILT_MUL;
        end
      end
      ST_TILT_MUL: begin
        if (!mul_busy) begin
          ld_blend  = 1'b1;
          state_nxt = ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        ld_smooth = 1'b1;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        mul_start  = 1'b1;
        mul_mcand  = gain_mcand;
        mul_mplier = gain_r;
        state_nxt  = ST_VEL;
      end
      ST_VEL: begin
        if (!mul_busy) begin
          ld_vel    = 1'b1;
          state_nxt = ST_POSITION;
        end
      end
      ST_POSITION: begin
        if (!out_valid_r || out_tready) begin
          ld_out    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      say_r       <= '0;
      saz_r       <= '0;
      blend_r     <= '0;
      smooth_r    <= '0;
      top_r       <= TOP_RESET;
      gain_r      <= GAIN_RESET;
      limit_r     <= LIMIT_RESET;
      pmax_r      <= PMAX_RESET;
      center_r    <= CENTER_RESET;
    end else begin
      state_r <= state_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ld_filter) begin
        say_r <= say_new;
        saz_r <= saz_new;
      end
      if (ld_blend) begin
        blend_r <= blend_new;
      end
      if (ld_smooth) begin
        smooth_r <= smooth_new;
      end
      if (ld_out) begin
        top_r <= top_new;
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_VELOCITY_GAIN:  gain_r   <= cfg_data[GAIN_W-1:0];
          REG_VELOCITY_LIMIT: limit_r  <= cfg_data[LIMIT_W-1:0];
          REG_POSITION_MAX:   pmax_r   <= cfg_data[PMAX_W-1:0];
          REG_CENTER_ANGLE:   center_r <= cfg_data[CENTER_W-1:0];
          default: begin
          end
        endcase
      end
    end
    if (accept) begin
      ay_r <= $signed(in_tdata[ACCEL_W-1:0]);
      az_r <= $signed(in_tdata[2*ACCEL_W-1:ACCEL_W]);
      gx_r <= $signed(in_tdata[2*ACCEL_W+GYRO_W-1:2*ACCEL_W]);
    end
    if (ld_tilt) begin
      tilt_r <= tilt_new;
    end
    if (ld_decay) begin
      decay_r <= mul_product;
    end
    if (ld_vel) begin
      vel_r <= vel_new;
    end
    if (ld_out) begin
      out_data_r <= {{(OUT_TDATA_W-TILT_W-ANGLE_W-VEL_W-POS_W){1'b0}},
                     top_new, vel_r, smooth_r, tilt_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/itpd_serial_mul.sv
// ----------------------------------------------------------------------------
// itpd_serial_mul: bit-serial shift-and-add multiplier
// Multiplies a signed operand by an unsigned one, one multiplier bit per
// cycle, and gives the product floored by the fraction width.
// ----------------------------------------------------------------------------
module itpd_serial_mul import itpd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [MUL_A_W-1:0] mcand,
  input  logic        [MUL_B_W-1:0] mplier,
  output logic                      busy,
  output logic signed [MUL_P_W-1:0] product
);

  logic        [MUL_CNT_W-1:0] count_r, count_nxt;
  logic signed [MUL_A_W-1:0]   mcand_r, mcand_nxt;
  logic signed [MUL_A_W:0]     hi_r, hi_nxt;
  logic        [MUL_B_W-1:0]   lo_r, lo_nxt;
  logic signed [MUL_A_W:0]     sum;
  logic        [MUL_A_W+MUL_B_W:0] full;

  always_comb begin
    sum       = hi_r + (lo_r[0] ? (MUL_A_W+1)'(mcand_r) : '0);
    count_nxt = count_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    if (start) begin
      count_nxt = MUL_CNT_W'(MUL_B_W);
      mcand_nxt = mcand;
      hi_nxt    = '0;
      lo_nxt    = mplier;
    end else if (count_r != '0) begin
      count_nxt = count_r - MUL_CNT_W'(1);
      hi_nxt    = sum >>> 1;
      lo_nxt    = {sum[0], lo_r[MUL_B_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  assign full    = {hi_r, lo_r};
  assign busy    = (count_r != '0);
  assign product = $signed(full[FRACTION_BITS +: MUL_P_W]);

endmodule

### rtl/itpd_cordic.sv
// ----------------------------------------------------------------------------
// itpd_cordic: iterative vectoring CORDIC arctangent in degrees
// One rotation step per cycle with x and y shifters and the arctangent
// table; the left half-plane is pre-rotated by a quarter turn on load.
// ----------------------------------------------------------------------------
module itpd_cordic import itpd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [ACCEL_W-1:0] x_in,
  input  logic signed [ACCEL_W:0]   y_in,
  output logic                      busy,
  output logic signed [Z_W-1:0]     angle
);

  logic                       busy_r, busy_nxt;
  logic        [STEP_W-1:0]   step_r, step_nxt;
  logic                       zero_r, zero_nxt;
  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]      z_r, z_nxt;
  logic signed [CORDIC_W-1:0] x_ext, y_ext, x_sh, y_sh;
  logic        [Z_W-1:0]      atan_step;

  always_comb begin
    x_ext     = CORDIC_W'(x_in);
    y_ext     = CORDIC_W'(y_in);
    x_sh      = x_r >>> step_r;
    y_sh      = y_r >>> step_r;
    atan_step = atan_q(TABLE_IDX_W'(step_r));
    busy_nxt  = busy_r;
    step_nxt  = step_r;
    zero_nxt  = zero_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      zero_nxt = (x_in == '0) && (y_in == '0);
      z_nxt    = '0;
      x_nxt    = x_ext;
      y_nxt    = y_ext;
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_nxt = y_ext;
          y_nxt = -x_ext;
          z_nxt = Z_DEG_90;
        end else begin
          x_nxt = -y_ext;
          y_nxt = x_ext;
          z_nxt = -Z_DEG_90;
        end
      end
    end else if (busy_r) begin
      if (!zero_r) begin
        if (y_r > 0) begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + $signed(atan_step);
        end else begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - $signed(atan_step);
        end
      end
      if (step_r == STEP_W'(ARCTAN_STEPS - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    zero_r <= zero_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
  end

  assign busy  = busy_r;
  assign angle = z_r;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tilt-controlled paddle
// Drives IMU sample beats with bursty timing against a stalling receiver,
// predicts every result beat from an independent fixed-point model of the
// filters, arctangent, blend and paddle integration, and compares each
// result field by field. Register settings are swept between phases.
// ----------------------------------------------------------------------------
module testbench;
  import itpd_pkg::*;

  localparam int     Q_BITS        = 16;
  localparam int     SMOOTH_SHIFT  = 4;
  localparam int     CORDIC_STEPS  = 16;
  localparam longint ONE_Q         = 64'sd1 << Q_BITS;
  localparam longint MIX_SMALL     = (64'sd1 << Q_BITS) / 1000;
  localparam longint MIX_LARGE     = (64'sd999 << Q_BITS) / 1000;
  localparam longint BLEND_HI      = 64'sd2147483647;
  localparam longint BLEND_LO      = -64'sd2147483648;
  localparam int     ACCEL_MAX     = 2097151;
  localparam int     ACCEL_MIN     = -2097152;
  localparam int     GYRO_MAX      = 134217727;
  localparam int     GYRO_MIN      = -134217728;
  localparam int     RESULT_BITS   = TILT_W + ANGLE_W + VEL_W + POS_W;
  localparam int     DUT_LATENCY   = 80;
  localparam int     QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic signed [GYRO_W-1:0]  gyro_x;
  } tilt_sample_t;

  typedef struct packed {
    logic [TILT_W-1:0]        accel_tilt;
    logic [ANGLE_W-1:0]       filtered_angle;
    logic signed [VEL_W-1:0]  paddle_velocity;
    logic [POS_W-1:0]         paddle_position;
  } paddle_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_VELOCITY_GAIN;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Predicted block state and register copies.
  longint lp_accel_y, lp_accel_z, blend_q, lp_angle, top_q;
  longint gain_q, limit_q, pmax_q, center_q;

  paddle_result_t expected_paddle_q[$];
  int samples_sent, results_checked, fail_count, settings_count;
  int velocity_clamps, position_stops;
  int burst_left, quiet_cycles;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_mode_left, rx_hold;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  imu_tilt_complementary_paddle dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  function automatic longint mul_q(longint a, longint b);
    return (a * b) >>> Q_BITS;
  endfunction

  function automatic longint clamp_q(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Arctangent of 2^-i in degrees, rounded half up from a 2^32 scale.
  function automatic longint arctan_step_q(int i);
    longint d;
    case (i)
      0:  d = 64'd193273528320;
      1:  d = 64'd114096026022;
      2:  d = 64'd60285206653;
      3:  d = 64'd30601712202;
      4:  d = 64'd15360239180;
      5:  d = 64'd7687607525;
      6:  d = 64'd3844741810;
      7:  d = 64'd1922488225;
      8:  d = 64'd961258780;
      9:  d = 64'd480631223;
      10: d = 64'd240315841;
      11: d = 64'd120157949;
      12: d = 64'd60078978;
      13: d = 64'd30039489;
      14: d = 64'd15019745;
      15: d = 64'd7509872;
      default: d = 0;
    endcase
    return (d + (64'sd1 << (31 - Q_BITS))) >>> (32 - Q_BITS);
  endfunction

  function automatic longint atan2_deg_q(longint x, longint y);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * ONE_Q;
      end else begin
        x = -y;
        y = t;
        z = -90 * ONE_Q;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arctan_step_q(i);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - arctan_step_q(i);
      end
    end
    return z;
  endfunction

  function automatic void reset_paddle_model();
    lp_accel_y = 0;
    lp_accel_z = 0;
    blend_q    = 0;
    lp_angle   = 0;
    top_q      = 240 * ONE_Q;
    gain_q     = (64'sd5 << Q_BITS) / 1000;
    limit_q    = (64'sd9 << Q_BITS) / 10;
    pmax_q     = 420 * ONE_Q;
    center_q   = 90 * ONE_Q;
  endfunction

  function automatic paddle_result_t predict_paddle(tilt_sample_t s);
    longint tilt, vel, next_top;
    paddle_result_t r;
    lp_accel_y = lp_accel_y + ((longint'(s.accel_y) - lp_accel_y) >>> SMOOTH_SHIFT);
    lp_accel_z = lp_accel_z + ((longint'(s.accel_z) - lp_accel_z) >>> SMOOTH_SHIFT);
    tilt = clamp_q(atan2_deg_q(lp_accel_y, -lp_accel_z) + 180 * ONE_Q, 0, 360 * ONE_Q);
    blend_q = mul_q(blend_q + mul_q(longint'(s.gyro_x), MIX_SMALL), MIX_LARGE)
              + mul_q(tilt, MIX_SMALL);
    blend_q = clamp_q(blend_q, BLEND_LO, BLEND_HI);
    lp_angle = lp_angle + ((blend_q - lp_angle) >>> SMOOTH_SHIFT);
    lp_angle = clamp_q(lp_angle, 0, 180 * ONE_Q);
    vel = -mul_q(lp_angle - center_q, gain_q);
    if (vel > limit_q || vel < -limit_q) velocity_clamps++;
    if (vel > limit_q) vel = limit_q;
    if (vel < -limit_q) vel = -limit_q;
    next_top = top_q + vel;
    if (next_top <= 0) begin
      top_q = 0;
      position_stops++;
    end else if (next_top >= pmax_q) begin
      top_q = pmax_q;
      position_stops++;
    end else begin
      top_q = next_top;
    end
    r.accel_tilt      = TILT_W'(tilt);
    r.filtered_angle  = ANGLE_W'(lp_angle);
    r.paddle_velocity = VEL_W'(vel);
    r.paddle_position = POS_W'(top_q);
    return r;
  endfunction

  function automatic tilt_sample_t make_sample(int ay, int az, int gx);
    tilt_sample_t s;
    s.accel_y = ACCEL_W'(ay);
    s.accel_z = ACCEL_W'(az);
    s.gyro_x  = GYRO_W'(gx);
    return s;
  endfunction

  // Sender: bursts of back-to-back beats separated by random gaps.
  task automatic send_sample(tilt_sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {s.gyro_x, s.accel_z, s.accel_y};
    do @(posedge clk); while (!in_tready);
    expected_paddle_q.push_back(predict_paddle(s));
    samples_sent++;
  endtask

  task automatic finish_phase();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_paddle_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_VELOCITY_GAIN:  gain_q   = longint'(value[GAIN_W-1:0]);
      REG_VELOCITY_LIMIT: limit_q  = longint'(value[LIMIT_W-1:0]);
      REG_POSITION_MAX:   pmax_q   = longint'(value[PMAX_W-1:0]);
      REG_CENTER_ANGLE:   center_q = longint'(value[CENTER_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_settings(int gain, int limit, int pmax, int center);
    write_cfg(REG_VELOCITY_GAIN, CFG_DATA_W'(gain));
    write_cfg(REG_VELOCITY_LIMIT, CFG_DATA_W'(limit));
    write_cfg(REG_POSITION_MAX, CFG_DATA_W'(pmax));
    write_cfg(REG_CENTER_ANGLE, CFG_DATA_W'(center));
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  // Mostly steady orientations held for a run with small noise and a gyro
  // bias, so that the filters settle and the angle and paddle clamps are
  // reached; the rest is raw random bits and field extremes.
  task automatic send_random_samples(int count);
    int run_left, kind, base_y, base_z, gyro_bias;
    int ay, az, gx;
    run_left = 0;
    kind = 0;
    base_y = 0;
    base_z = 0;
    gyro_bias = 0;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 60);
        kind = $urandom_range(0, 9);
        base_y = int'($urandom_range(0, 2097152)) - 1048576;
        base_z = int'($urandom_range(0, 2097152)) - 1048576;
        case ($urandom_range(0, 3))
          0: gyro_bias = 0;
          1: gyro_bias = int'($urandom_range(0, 26214400)) - 13107200;
          default: gyro_bias = int'($urandom_range(0, 262144000)) - 131072000;
        endcase
      end
      run_left--;
      if (kind < 7) begin
        ay = base_y + int'($urandom_range(0, 8191)) - 4096;
        az = base_z + int'($urandom_range(0, 8191)) - 4096;
        gx = gyro_bias + int'($urandom_range(0, 131071)) - 65536;
      end else if (kind < 9) begin
        ay = int'($urandom);
        az = int'($urandom);
        gx = int'($urandom);
      end else begin
        ay = $urandom_range(0, 1) ? ACCEL_MAX : ACCEL_MIN;
        az = $urandom_range(0, 1) ? ACCEL_MAX : ($urandom_range(0, 1) ? ACCEL_MIN : 0);
        gx = $urandom_range(0, 1) ? GYRO_MAX : GYRO_MIN;
      end
      send_sample(make_sample(ay, az, gx));
    end
  endtask

  // Reset register values, the zero vector, both half-planes including the
  // negative x axis, and the extremes and alternating bit patterns of every
  // field.
  task automatic test_special_cases();
    repeat (2) send_sample(make_sample(0, 0, 0));
    send_sample(make_sample(ACCEL_MAX, 0, 0));
    repeat (3) send_sample(make_sample(ACCEL_MIN, 0, 0));
    repeat (2) send_sample(make_sample(ACCEL_MIN, ACCEL_MIN, 0));
    repeat (3) send_sample(make_sample(ACCEL_MIN, ACCEL_MAX, 0));
    repeat (3) send_sample(make_sample(0, 0, GYRO_MAX));
    repeat (3) send_sample(make_sample(0, 0, GYRO_MIN));
    send_sample(make_sample(ACCEL_MAX, ACCEL_MIN, GYRO_MAX));
    send_sample(make_sample(ACCEL_MIN, ACCEL_MAX, GYRO_MIN));
    send_sample(make_sample(1398101, -1398102, 89478485));
    send_sample(make_sample(-1398102, 1398101, -89478486));
    finish_phase();
  endtask

  task automatic test_register_extremes();
    apply_settings(0, 0, 0, 0);
    send_random_samples(90);
    finish_phase();
    apply_settings(131071, 131071, 33554431, 16777215);
    send_random_samples(90);
    finish_phase();
    apply_settings(65536, 65536, 31457280, 11796480);
    send_random_samples(90);
    finish_phase();
    apply_settings(131071, 65536, 1000, 0);
    send_random_samples(90);
    finish_phase();
    apply_settings(131071, 0, 33554431, 5898240);
    send_random_samples(90);
    finish_phase();
  endtask

  task automatic test_random_settings();
    int gain, limit, pmax, center;
    repeat (4) begin
      if ($urandom_range(0, 3) == 0) begin
        gain   = $urandom_range(0, 131071);
        limit  = $urandom_range(0, 131071);
        pmax   = $urandom_range(0, 33554431);
        center = $urandom_range(0, 16777215);
      end else begin
        gain   = $urandom_range(0, 65536);
        limit  = $urandom_range(0, 65536);
        pmax   = $urandom_range(0, 31457280);
        center = $urandom_range(0, 11796480);
      end
      apply_settings(gain, limit, pmax, center);
      send_random_samples(110);
      finish_phase();
    end
  endtask

  // Receiver: switches between always ready, coin-toss ready and long stalls.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_mode_left <= $urandom_range(100, 600);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_COIN: out_tready <= $urandom_range(0, 1);
      default: begin
        if (rx_hold == 0) begin
          out_tready <= 1'b1;
          rx_hold <= $urandom_range(1, 20);
        end else begin
          out_tready <= 1'b0;
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    paddle_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      {got.paddle_position, got.paddle_velocity, got.filtered_angle, got.accel_tilt}
        = out_tdata[RESULT_BITS-1:0];
      results_checked++;
      if (expected_paddle_q.size() == 0) begin
        fail_count++;
        $display("%0t: result beat expected none, actual %h", $time, out_tdata);
      end else begin
        want = expected_paddle_q.pop_front();
        compare_field("accel_tilt", longint'(want.accel_tilt), longint'(got.accel_tilt));
        compare_field("filtered_angle", longint'(want.filtered_angle),
                      longint'(got.filtered_angle));
        compare_field("paddle_velocity", longint'(want.paddle_velocity),
                      longint'(got.paddle_velocity));
        compare_field("paddle_position", longint'(want.paddle_position),
                      longint'(got.paddle_position));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("imu_tilt_complementary_paddle: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_paddle_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_register_extremes();
    test_random_settings();
    finish_phase();
    repeat (2 * DUT_LATENCY) @(posedge clk);
    $display("Sent %0d samples under %0d register settings; %0d results compared.",
             samples_sent, settings_count + 1, results_checked);
    $display("Velocity clamped in %0d results, paddle stopped at a screen edge in %0d.",
             velocity_clamps, position_stops);
    if (fail_count == 0 && expected_paddle_q.size() == 0) begin
      $display("imu_tilt_complementary_paddle: match");
    end else begin
      $display("imu_tilt_complementary_paddle: mismatch");
    end
    $finish;
  end

endmodule

### imu_tilt_complementary_paddle.f
rtl/itpd_pkg.sv
rtl/itpd_serial_mul.sv
rtl/itpd_cordic.sv
rtl/imu_tilt_complementary_paddle.sv
dv/testbench.sv
